/* rtl/fpc_pkg.sv */
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the first-person camera integrator
// Beat layouts, command codes, fixed-point widths and the CORDIC arc table.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int ANGLE_W  = 16;
  localparam int POS_W    = 32;
  localparam int SPEED_W  = 16;
  localparam int DT_W     = 16;

  // Command codes; codes above CMD_SET_POS are ignored.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_SET_MOTION = 3'd1;
  localparam logic [2:0] CMD_SET_PITCH  = 3'd2;
  localparam logic [2:0] CMD_SET_YAW    = 3'd3;
  localparam logic [2:0] CMD_SET_POS    = 3'd4;

  // Motion codes for both axes; the spare code is stored as no motion.
  localparam logic [1:0] MOTION_NONE   = 2'd0;
  localparam logic [1:0] MOTION_POS    = 2'd1;
  localparam logic [1:0] MOTION_NEG    = 2'd2;
  localparam logic [1:0] MOTION_UNUSED = 2'd3;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd16384;

  // CORDIC datapath: Q2.30 values carried with guard bits.
  localparam int CORDIC_W = 34;
  localparam int ARC_LEN  = 24;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Sine and cosine in Q.16, wide enough to hold a negated full scale.
  localparam int TRIG_W = 19;

  // Shared multiplier: unsigned scale times signed vector component.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = TRIG_W;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

  typedef struct packed {
    logic [2:0]                command;
    logic [DT_W-1:0]           time_step;
    logic [1:0]                forward_back;
    logic [1:0]                strafe;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [POS_W-1:0]   new_x;
    logic signed [POS_W-1:0]   new_y;
    logic signed [POS_W-1:0]   new_z;
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [ANGLE_W-1:0] pitch_now;
    logic signed [ANGLE_W-1:0] yaw_now;
  } pose_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // Arc tangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] arc_angle(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/first_person_camera_integrator_unit.sv */
// ----------------------------------------------------------------------------
// first_person_camera_integrator_unit: first-person camera pose integrator
// Keeps position, pitch, yaw and motion flags; a tick moves the camera along
// its forward and right vectors using a shared CORDIC and multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                        Direction  Meaning
//  cmd       cmd_valid/cmd_ready/cmd_beat   in         one command per beat
//  pose      pose_valid/pose_ready/pose_beat out       pose after each command
//  speed     speed_we/speed_wdata           in         Q8.8 speed register
//
// A set command goes from idle to S_DONE, which registers its pose beat once
// the pose output is free and returns the block to idle. A tick passes
// through S_SCALE, S_YAW, S_PITCH, then S_MUL and S_ACC for each active
// component, and S_DONE. The CORDIC unit is run once for yaw and once for
// pitch, each time waiting in its state for the CORDIC done strobe.
// Reset is synchronous and restores the power-up pose and a speed of 256.
// The pose output is a register: a new command is accepted while the last
// pose beat is still waiting, and a stalled pose beat only holds the block
// when the next result is ready to be written.
// ----------------------------------------------------------------------------
module first_person_camera_integrator_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  fpc_pkg::cmd_t                       cmd_beat,
  output logic                                pose_valid,
  input  logic                                pose_ready,
  output fpc_pkg::pose_t                      pose_beat,
  input  logic                                speed_we,
  input  logic [fpc_pkg::SPEED_W-1:0]         speed_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_YAW,
    S_PITCH,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

  // One entry for each nonzero vector component, forward vector first.
  typedef enum logic [2:0] {
    C_FX,
    C_FY,
    C_FZ,
    C_RX,
    C_RZ
  } comp_t;

  localparam int PW = fpc_pkg::POS_W;
  localparam int DW = 28;            // width of a signed movement delta

  state_t state;
  comp_t  comp;

  // Architectural state.
  logic [fpc_pkg::SPEED_W-1:0]         speed;
  logic signed [PW-1:0]                position_x, position_y, position_z;
  logic signed [fpc_pkg::ANGLE_W-1:0]  pitch_angle, yaw_angle;
  logic [1:0]                          fore_aft_motion, side_motion;

  // Tick working registers.
  logic [fpc_pkg::MUL_A_W-1:0]         scale;
  logic signed [fpc_pkg::TRIG_W-1:0]   sin_yaw, cos_yaw, sin_pitch;

  logic                                cmd_fire;
  logic                                cordic_start;
  logic                                cordic_done;
  logic signed [fpc_pkg::ANGLE_W-1:0]  cordic_angle;
  fpc_pkg::trig_t                      cordic_result;

  logic [fpc_pkg::MUL_A_W-1:0]         mul_a;
  logic signed [fpc_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [fpc_pkg::PROD_W-1:0]   mul_prod;

  logic signed [fpc_pkg::PROD_W-1:0]   prod_shift;
  logic signed [DW-1:0]                delta;
  logic                                delta_neg;
  logic signed [PW-1:0]                acc_base;
  logic signed [PW+1:0]                acc_sum;
  logic signed [PW-1:0]                acc_sat;
  logic                                fore_on, side_on;
  logic signed [fpc_pkg::ANGLE_W-1:0]  pitch_clamped;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign fore_on   = (fore_aft_motion != fpc_pkg::MOTION_NONE);
  assign side_on   = (side_motion != fpc_pkg::MOTION_NONE);

  // The CORDIC runs on yaw when a tick is accepted and on pitch right after.
  assign cordic_start = (cmd_fire && cmd_beat.command == fpc_pkg::CMD_TICK) ||
                        (state == S_YAW && cordic_done);
  assign cordic_angle = (state == S_IDLE) ? yaw_angle : pitch_angle;

  fpc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cordic_start),
    .angle  (cordic_angle),
    .done   (cordic_done),
    .result (cordic_result)
  );

  // In idle the multiplier forms speed * time_step; afterwards it forms
  // scale * component for each component of an active axis.
  always_comb begin
    if (state == S_IDLE) begin
      mul_a = {{(fpc_pkg::MUL_A_W-fpc_pkg::SPEED_W){1'b0}}, speed};
      mul_b = $signed({{(fpc_pkg::MUL_B_W-fpc_pkg::DT_W){1'b0}}, cmd_beat.time_step});
    end else begin
      mul_a = scale;
      unique case (comp)
        C_FX:    mul_b = -sin_yaw;
        C_FY:    mul_b = sin_pitch;
        C_FZ:    mul_b = -cos_yaw;
        C_RX:    mul_b = cos_yaw;
        C_RZ:    mul_b = -sin_yaw;
        default: mul_b = '0;
      endcase
    end
  end

  fpc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  // Delta is floor(product / 2^24), negated for backward or left motion,
  // then added to its axis with saturation.
  always_comb begin
    prod_shift = mul_prod >>> 24;
    delta_neg  = (comp == C_RX || comp == C_RZ) ?
                 (side_motion == fpc_pkg::MOTION_NEG) :
                 (fore_aft_motion == fpc_pkg::MOTION_NEG);
    delta      = delta_neg ? -prod_shift[DW-1:0] : prod_shift[DW-1:0];
    unique case (comp)
      C_FX, C_RX: acc_base = position_x;
      C_FY:       acc_base = position_y;
      default:    acc_base = position_z;
    endcase
    acc_sum = {{2{acc_base[PW-1]}}, acc_base} + {{(PW+2-DW){delta[DW-1]}}, delta};
    if (acc_sum > $signed({2'b00, {(PW-1){1'b1}}}) ) begin
      acc_sat = {1'b0, {(PW-1){1'b1}}};
    end else if (acc_sum < $signed({2'b11, 1'b1, {(PW-1){1'b0}}})) begin
      acc_sat = {1'b1, {(PW-1){1'b0}}};
    end else begin
      acc_sat = acc_sum[PW-1:0];
    end
  end

  always_comb begin
    if (cmd_beat.angle > fpc_pkg::QUARTER_TURN) begin
      pitch_clamped = fpc_pkg::QUARTER_TURN;
    end else if (cmd_beat.angle < -fpc_pkg::QUARTER_TURN) begin
      pitch_clamped = -fpc_pkg::QUARTER_TURN;
    end else begin
      pitch_clamped = cmd_beat.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      comp            <= C_FX;
      pose_valid      <= 1'b0;
      speed           <= 16'd256;
      position_x      <= '0;
      position_y      <= '0;
      position_z      <= '0;
      pitch_angle     <= '0;
      yaw_angle       <= '0;
      fore_aft_motion <= fpc_pkg::MOTION_NONE;
      side_motion     <= fpc_pkg::MOTION_NONE;
    end else begin
      if (speed_we) begin
        speed <= speed_wdata;
      end
      if (pose_valid && pose_ready) begin
        pose_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            state <= S_DONE;
            priority case (cmd_beat.command)
              fpc_pkg::CMD_TICK: begin
                state <= S_SCALE;
              end
              fpc_pkg::CMD_SET_MOTION: begin
                // The spare code on either axis means no motion.
                fore_aft_motion <= (cmd_beat.forward_back == fpc_pkg::MOTION_UNUSED) ?
                                   fpc_pkg::MOTION_NONE : cmd_beat.forward_back;
                side_motion     <= (cmd_beat.strafe == fpc_pkg::MOTION_UNUSED) ?
                                   fpc_pkg::MOTION_NONE : cmd_beat.strafe;
              end
              fpc_pkg::CMD_SET_PITCH: begin
                pitch_angle <= pitch_clamped;
              end
              fpc_pkg::CMD_SET_YAW: begin
                yaw_angle <= cmd_beat.angle;
              end
              fpc_pkg::CMD_SET_POS: begin
                position_x <= cmd_beat.new_x;
                position_y <= cmd_beat.new_y;
                position_z <= cmd_beat.new_z;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCALE: begin
          scale <= mul_prod[fpc_pkg::MUL_A_W-1:0];
          state <= S_YAW;
        end
        S_YAW: begin
          if (cordic_done) begin
            sin_yaw <= cordic_result.sin_v;
            cos_yaw <= cordic_result.cos_v;
            state   <= S_PITCH;
          end
        end
        S_PITCH: begin
          if (cordic_done) begin
            sin_pitch <= cordic_result.sin_v;
            if (fore_on) begin
              comp  <= C_FX;
              state <= S_MUL;
            end else if (side_on) begin
              comp  <= C_RX;
              state <= S_MUL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          unique case (comp)
            C_FX, C_RX: position_x <= acc_sat;
            C_FY:       position_y <= acc_sat;
            default:    position_z <= acc_sat;
          endcase
          state <= S_MUL;
          unique case (comp)
            C_FX: comp <= C_FY;
            C_FY: comp <= C_FZ;
            C_FZ: begin
              if (side_on) begin
                comp <= C_RX;
              end else begin
                state <= S_DONE;
              end
            end
            C_RX: comp <= C_RZ;
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!pose_valid || pose_ready) begin
            pose_valid          <= 1'b1;
            pose_beat.pos_x     <= position_x;
            pose_beat.pos_y     <= position_y;
            pose_beat.pos_z     <= position_z;
            pose_beat.pitch_now <= pitch_angle;
            pose_beat.yaw_now   <= yaw_angle;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/fpc_mul.sv */
// ----------------------------------------------------------------------------
// fpc_mul: shared registered multiplier
// Multiplies an unsigned 32-bit operand by a signed vector component or time step.
// ----------------------------------------------------------------------------
module fpc_mul (
  input  logic                                  clk,
  input  logic [fpc_pkg::MUL_A_W-1:0]           op_a,
  input  logic signed [fpc_pkg::MUL_B_W-1:0]    op_b,
  output logic signed [fpc_pkg::PROD_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, op_a}) * op_b;
  end

endmodule

/* rtl/fpc_cordic.sv */
// ----------------------------------------------------------------------------
// fpc_cordic: iterative sine and cosine unit
// Reduces the angle to a half circle, runs one rotation step per cycle and
// rounds the result to Q.16 in a final registered step.
// ----------------------------------------------------------------------------
module fpc_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [fpc_pkg::ANGLE_W-1:0]     angle,
  output logic                                   done,
  output fpc_pkg::trig_t                         result
);

  localparam int CW = $clog2(STEPS);
  localparam int W  = fpc_pkg::CORDIC_W;

  logic                busy;
  logic                fin;
  logic                flip;
  logic [CW-1:0]       cnt;
  logic signed [W-1:0] x, y, z;

  logic signed [fpc_pkg::ANGLE_W:0] ang_wide;
  logic signed [fpc_pkg::ANGLE_W:0] ang_red;
  logic                             flip_next;
  logic signed [W-1:0]              xs, ys, arc;
  logic signed [W-1:0]              x_rnd, y_rnd;
  logic signed [fpc_pkg::TRIG_W-1:0] cos_r, sin_r;

  always_comb begin
    ang_wide  = {angle[fpc_pkg::ANGLE_W-1], angle};
    ang_red   = ang_wide;
    flip_next = 1'b0;
    if (ang_wide > $signed({1'b0, fpc_pkg::QUARTER_TURN})) begin
      ang_red   = ang_wide - 17'sd32768;
      flip_next = 1'b1;
    end else if (ang_wide < -$signed({1'b0, fpc_pkg::QUARTER_TURN})) begin
      ang_red   = ang_wide + 17'sd32768;
      flip_next = 1'b1;
    end
  end

  always_comb begin
    xs    = x >>> cnt;
    ys    = y >>> cnt;
    arc   = $signed({{(W-32){1'b0}}, fpc_pkg::arc_angle(5'(cnt))});
    x_rnd = (x + 34'sd8192) >>> 14;
    y_rnd = (y + 34'sd8192) >>> 14;
    cos_r = x_rnd[fpc_pkg::TRIG_W-1:0];
    sin_r = y_rnd[fpc_pkg::TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        flip <= flip_next;
        x    <= fpc_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= $signed({{(W-fpc_pkg::ANGLE_W-16){ang_red[fpc_pkg::ANGLE_W-1]}},
                         ang_red[fpc_pkg::ANGLE_W-1:0], 16'b0});
      end else if (busy) begin
        if (!z[W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - arc;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + arc;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        result.cos_v <= flip ? -cos_r : cos_r;
        result.sin_v <= flip ? -sin_r : sin_r;
      end
    end
  end

endmodule

/* rtl/fpc_checker.sv */
// ----------------------------------------------------------------------------
// fpc_checker: port-level checks of the camera integrator
// Watches the command and pose channels and is bound to the top level.
// ----------------------------------------------------------------------------
module fpc_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input fpc_pkg::cmd_t  cmd_beat,
  input logic           pose_valid,
  input logic           pose_ready,
  input fpc_pkg::pose_t pose_beat
);

  // A stalled pose beat holds its value.
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_ready |=> pose_valid && $stable(pose_beat))
    else $error("pose beat changed while stalled");

  // One command at a time: the block is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while previous one is in flight");

  // Reported pitch always stays within a quarter turn.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> (pose_beat.pitch_now <= fpc_pkg::QUARTER_TURN) &&
                   (pose_beat.pitch_now >= -fpc_pkg::QUARTER_TURN))
    else $error("pitch outside clamp range");

  // Reset leaves no pose pending and the block ready for a command.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !pose_valid && cmd_ready)
    else $error("bad state after reset");

endmodule

bind first_person_camera_integrator_unit fpc_checker u_fpc_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_ready  (cmd_ready),
  .cmd_beat   (cmd_beat),
  .pose_valid (pose_valid),
  .pose_ready (pose_ready),
  .pose_beat  (pose_beat)
);
